/* hw/rtl/ir_pulse_sequence_player_assert.svh */
// Assertion macros for the checker file of the IR pulse sequence player.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef IR_PULSE_SEQUENCE_PLAYER_ASSERT_SVH
`define IR_PULSE_SEQUENCE_PLAYER_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define IPSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle forces a condition in the next.
`define IPSP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/ipsp_pkg.sv */
// Package of the IR pulse sequence player: commands, status codes, states, limits.
// No dependencies.
package ipsp_pkg;

  localparam int unsigned StoreDepthDefault = 1024;
  localparam int unsigned MaxEntries        = 1018;

  localparam logic [23:0] TickHz       = 24'd16000000;
  localparam logic [15:0] ChunkMax     = 16'hFFFF;
  localparam logic [19:0] FreqMin      = 20'd20000;
  localparam logic [19:0] FreqMax      = 20'd500000;
  localparam logic [15:0] CountMax     = 16'd31;
  localparam logic [7:0]  CountDefault = 8'd150;

  localparam logic [9:0]  PeriodMin    = 10'd32;
  localparam logic [9:0]  PeriodMax    = 10'd800;

  typedef enum logic [1:0] {
    CmdLoad   = 2'd0,
    CmdStart  = 2'd1,
    CmdExpiry = 2'd2,
    CmdStop   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegFreq   = 2'd0,
    RegRepeat = 2'd1,
    RegOffset = 2'd2,
    RegLength = 2'd3
  } cfg_idx_e;

  localparam logic [3:0] StOk        = 4'd0;
  localparam logic [3:0] StLength    = 4'd1;
  localparam logic [3:0] StBusy      = 4'd2;
  localparam logic [3:0] StFreq      = 4'd3;
  localparam logic [3:0] StCount     = 4'd4;
  localparam logic [3:0] StOffset    = 4'd5;
  localparam logic [3:0] StShort     = 4'd6;
  localparam logic [3:0] StOddLength = 4'd7;
  localparam logic [3:0] StOffsetEnd = 4'd8;

  typedef enum logic [2:0] {
    StateIdle,
    StateDiv,
    StateRead,
    StateMul,
    StateEmit
  } state_e;

endpackage

/* hw/rtl/ir_pulse_sequence_player.sv */
// IR pulse sequence player: duration store, start checks, carrier period divider
// and mark/space playback. Uses ipsp_pkg.
//
// Usage: an item (command_i, entry_index_i, entry_value_i) is taken when start_i
// is high and busy_o is low. Load items write the duration store and give no
// result. Start checks the settings; on error the status shows in the cycle after
// the transfer. On success the carrier period 16000000/carrier_freq is worked
// out by a restoring divider, one quotient bit a cycle, then the first entry is
// read from the store, scaled by the period and the first timer shot is given.
// A timer expiry while running reads the store, multiplies when no remainder
// is left and emits; after the last repeat it gives its finish result from the
// read state instead. A stop while running gives its result from idle.
// Each result is shown for one cycle with done_o high; the receiver cannot
// stall, so nothing is held back. busy_o stays high until the result of the
// item is registered. Configuration writes go through cfg_valid_i/cfg_ready_o,
// always ready, and are meant to happen while the block is idle. Reset clears
// the control state and loads the register defaults; store contents are
// undefined until loaded.
module ir_pulse_sequence_player #(
  parameter int unsigned STORE_DEPTH = ipsp_pkg::StoreDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  output logic        done_o,
  output logic [3:0]  status_o,
  output logic        carrier_on_o,
  output logic [9:0]  carrier_period_o,
  output logic [15:0] chunk_ticks_o,
  output logic        finished_o
);
  import ipsp_pkg::*;

  localparam int unsigned AW       = $clog2(STORE_DEPTH);
  localparam int unsigned LenLimit = (MaxEntries < STORE_DEPTH) ? MaxEntries : STORE_DEPTH;

  // configuration registers
  logic [19:0] cfg_freq_q;
  logic [15:0] cfg_repeat_q;
  logic [9:0]  cfg_offset_q, cfg_len_q;

  // playback state
  state_e      state_q, state_d;
  logic        running_q, running_d;
  logic [9:0]  period_q, period_d;
  logic [7:0]  limit_q, limit_d;
  logic [9:0]  ptr_q, ptr_d;
  logic [7:0]  repeats_q, repeats_d;
  logic [25:0] rem_q, rem_d;
  logic        level_q, level_d;
  logic [9:0]  run_len_q, run_len_d;
  logic [9:0]  run_off_q, run_off_d;

  // divider
  logic [23:0] div_rem_q, div_rem_d;
  logic [28:0] div_dsh_q, div_dsh_d;
  logic [3:0]  div_cnt_q, div_cnt_d;

  // result register
  logic        done_q, done_d;
  logic [3:0]  status_q, status_d;
  logic        on_q, on_d;
  logic [9:0]  per_q, per_d;
  logic [15:0] chunk_q, chunk_d;
  logic        fin_q, fin_d;

  // store
  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [12:0] widx_ext, ridx_ext;

  logic        accept;
  cmd_e        cmd;
  logic [3:0]  start_st;
  logic [25:0] product;
  logic [15:0] chunk;
  logic [25:0] rem_left;
  logic [10:0] ptr_inc;

  assign accept = start_i && (state_q == StateIdle);
  assign cmd    = cmd_e'(command_i);

  assign widx_ext = {3'b000, entry_index_i};
  assign ridx_ext = {3'b000, ptr_q};
  assign waddr    = widx_ext[AW-1:0];
  assign raddr    = ridx_ext[AW-1:0];
  assign mem_we   = accept && (cmd == CmdLoad) && (widx_ext < 13'(STORE_DEPTH));
  assign mem_re   = (state_q == StateRead);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // start checks in priority order
  always_comb begin
    priority if ({3'b000, cfg_len_q} > 13'(LenLimit))                      start_st = StLength;
    else if (running_q)                                                     start_st = StBusy;
    else if ((cfg_freq_q < FreqMin) || (cfg_freq_q > FreqMax))              start_st = StFreq;
    else if (cfg_repeat_q > CountMax)                                       start_st = StCount;
    else if ((cfg_offset_q == 10'd0) || !cfg_offset_q[0])                   start_st = StOffset;
    else if (cfg_len_q < 10'd2)                                             start_st = StShort;
    else if (cfg_len_q[0])                                                  start_st = StOddLength;
    else if (cfg_offset_q > cfg_len_q)                                      start_st = StOffsetEnd;
    else                                                                    start_st = StOk;
  end

  assign product  = {16'd0, period_q} * {10'd0, rdata_q};
  assign chunk    = (rem_q > {10'd0, ChunkMax}) ? ChunkMax : rem_q[15:0];
  assign rem_left = rem_q - {10'd0, chunk};
  assign ptr_inc  = {1'b0, ptr_q} + 11'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          unique case (cmd)
            CmdStart:  state_d = (start_st == StOk) ? StateDiv : StateIdle;
            CmdExpiry: state_d = running_q ? StateRead : StateIdle;
            CmdLoad,
            CmdStop:   state_d = StateIdle;
            default:   state_d = StateIdle;
          endcase
        end
      end
      StateDiv:  state_d = (div_cnt_q == 4'd0) ? StateRead : StateDiv;
      StateRead: state_d = (repeats_q >= limit_q) ? StateIdle : StateMul;
      StateMul:  state_d = StateEmit;
      StateEmit: state_d = StateIdle;
      default:   state_d = StateIdle;
    endcase
  end

  // datapath and results
  always_comb begin
    running_d = running_q;
    period_d  = period_q;
    limit_d   = limit_q;
    ptr_d     = ptr_q;
    repeats_d = repeats_q;
    rem_d     = rem_q;
    level_d   = level_q;
    run_len_d = run_len_q;
    run_off_d = run_off_q;
    div_rem_d = div_rem_q;
    div_dsh_d = div_dsh_q;
    div_cnt_d = div_cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    on_d      = on_q;
    per_d     = per_q;
    chunk_d   = chunk_q;
    fin_d     = fin_q;
    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          unique case (cmd)
            CmdStart: begin
              if (start_st != StOk) begin
                done_d   = 1'b1;
                status_d = start_st;
                on_d     = 1'b0;
                per_d    = 10'd0;
                chunk_d  = 16'd0;
                fin_d    = 1'b0;
              end else begin
                limit_d   = (cfg_repeat_q == 16'd0) ? CountDefault : cfg_repeat_q[7:0];
                run_len_d = cfg_len_q;
                run_off_d = cfg_offset_q;
                level_d   = 1'b1;
                ptr_d     = 10'd0;
                repeats_d = 8'd0;
                rem_d     = 26'd0;
                running_d = 1'b1;
                div_rem_d = TickHz;
                div_dsh_d = {cfg_freq_q, 9'd0};
                div_cnt_d = 4'd9;
                period_d  = 10'd0;
              end
            end
            CmdStop: begin
              if (running_q) begin
                running_d = 1'b0;
                done_d    = 1'b1;
                status_d  = StOk;
                on_d      = 1'b0;
                per_d     = period_q;
                chunk_d   = 16'd0;
                fin_d     = 1'b1;
              end
            end
            CmdLoad,
            CmdExpiry: ;
            default: ;
          endcase
        end
      end
      StateDiv: begin
        // one quotient bit per cycle, MSB first
        if ({5'd0, div_rem_q} >= div_dsh_q) begin
          div_rem_d = div_rem_q - div_dsh_q[23:0];
          period_d  = {period_q[8:0], 1'b1};
        end else begin
          period_d  = {period_q[8:0], 1'b0};
        end
        div_dsh_d = {1'b0, div_dsh_q[28:1]};
        div_cnt_d = div_cnt_q - 4'd1;
      end
      StateRead: begin
        if (repeats_q >= limit_q) begin
          running_d = 1'b0;
          done_d    = 1'b1;
          status_d  = StOk;
          on_d      = 1'b0;
          per_d     = period_q;
          chunk_d   = 16'd0;
          fin_d     = 1'b1;
        end
      end
      StateMul: begin
        if (rem_q == 26'd0) begin
          rem_d = product;
        end
      end
      StateEmit: begin
        done_d   = 1'b1;
        status_d = StOk;
        on_d     = level_q;
        per_d    = period_q;
        chunk_d  = chunk;
        fin_d    = 1'b0;
        rem_d    = rem_left;
        if (rem_left == 26'd0) begin
          level_d = ~level_q;
          if (ptr_inc >= {1'b0, run_len_q}) begin
            repeats_d = repeats_q + 8'd1;
            ptr_d     = run_off_q - 10'd1;
          end else begin
            ptr_d     = ptr_inc[9:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_freq_q   <= 20'd38000;
      cfg_repeat_q <= 16'd0;
      cfg_offset_q <= 10'd1;
      cfg_len_q    <= 10'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        RegFreq:   cfg_freq_q   <= cfg_data_i;
        RegRepeat: cfg_repeat_q <= cfg_data_i[15:0];
        RegOffset: cfg_offset_q <= cfg_data_i[9:0];
        RegLength: cfg_len_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateIdle;
      running_q <= 1'b0;
      period_q  <= 10'd0;
      limit_q   <= 8'd0;
      ptr_q     <= 10'd0;
      repeats_q <= 8'd0;
      rem_q     <= 26'd0;
      level_q   <= 1'b0;
      run_len_q <= 10'd0;
      run_off_q <= 10'd0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      period_q  <= period_d;
      limit_q   <= limit_d;
      ptr_q     <= ptr_d;
      repeats_q <= repeats_d;
      rem_q     <= rem_d;
      level_q   <= level_d;
      run_len_q <= run_len_d;
      run_off_q <= run_off_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_dsh_q <= div_dsh_d;
    div_cnt_q <= div_cnt_d;
    status_q  <= status_d;
    on_q      <= on_d;
    per_q     <= per_d;
    chunk_q   <= chunk_d;
    fin_q     <= fin_d;
  end

  assign busy_o           = (state_q != StateIdle);
  assign cfg_ready_o      = 1'b1;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign carrier_on_o     = on_q;
  assign carrier_period_o = per_q;
  assign chunk_ticks_o    = chunk_q;
  assign finished_o       = fin_q;

endmodule

/* hw/rtl/ipsp_checker.sv */
// Port-level checker for the IR pulse sequence player, bound to the top level.
// Uses ipsp_pkg and ir_pulse_sequence_player_assert.svh.
`include "ir_pulse_sequence_player_assert.svh"

module ipsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  command_i,
  input logic        done_o,
  input logic [3:0]  status_o,
  input logic        carrier_on_o,
  input logic [9:0]  carrier_period_o,
  input logic [15:0] chunk_ticks_o,
  input logic        finished_o
);
  import ipsp_pkg::*;

  `IPSP_ASSERT(a_status_range, !done_o || (status_o <= StOffsetEnd), "status code out of range")

  `IPSP_ASSERT(a_error_zero, !(done_o && (status_o != StOk)) || (!carrier_on_o && (carrier_period_o == 10'd0) && (chunk_ticks_o == 16'd0) && !finished_o), "error result carries playback data")

  `IPSP_ASSERT(a_finish_quiet, !(done_o && finished_o) || (!carrier_on_o && (chunk_ticks_o == 16'd0) && (status_o == StOk)), "finish result with carrier or shot")

  `IPSP_ASSERT(a_period_range, !(done_o && (status_o == StOk)) || ((carrier_period_o >= PeriodMin) && (carrier_period_o <= PeriodMax)), "carrier period out of range")

  `IPSP_ASSERT_NEXT(a_load_silent, start_i && !busy_o && (command_i == CmdLoad), !done_o, "load transfer produced a result")

endmodule

bind ir_pulse_sequence_player ipsp_checker u_ipsp_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for ir_pulse_sequence_player: directed checks of every start error and
// playback case, then random mark/space sessions checked against a cycle-free predictor.
// Depends on ipsp_pkg and the ir_pulse_sequence_player RTL.
module tb;
  import ipsp_pkg::*;

  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic [3:0]  status;
    logic        on;
    logic [9:0]  period;
    logic [15:0] chunk;
    logic        fin;
  } shot_t;

  // Predicts the player's answers and holds them until the block shows them.
  class ir_player_board;
    logic [15:0] durations [1024];
    bit          written [1024];
    logic [19:0] freq;
    logic [15:0] rep_cfg;
    logic [9:0]  offset, seq_len;
    bit          running;
    logic [9:0]  period, ptr, run_len, run_off;
    logic [7:0]  rep_limit, reps_done;
    logic [25:0] remain;
    logic        level;
    shot_t       shots_due[$];
    int          errors;

    function new();
      freq = 20'd38000;
      rep_cfg = '0;
      offset = 10'd1;
      seq_len = '0;
      running = 1'b0;
      period = '0;
      ptr = '0;
      run_len = '0;
      run_off = '0;
      rep_limit = '0;
      reps_done = '0;
      remain = '0;
      level = 1'b0;
      errors = 0;
    endfunction

    function void take_reg(cfg_idx_e idx, logic [19:0] data);
      case (idx)
        RegFreq:   freq = data;
        RegRepeat: rep_cfg = data[15:0];
        RegOffset: offset = data[9:0];
        default:   seq_len = data[9:0];
      endcase
    endfunction

    function logic [3:0] start_status();
      if (seq_len > MaxEntries) return StLength;
      if (running) return StBusy;
      if (freq < FreqMin || freq > FreqMax) return StFreq;
      if (rep_cfg > CountMax) return StCount;
      if (offset == 0 || !offset[0]) return StOffset;
      if (seq_len < 2) return StShort;
      if (seq_len[0]) return StOddLength;
      if (offset > seq_len) return StOffsetEnd;
      return StOk;
    endfunction

    // Store entry that the item would read, or -1.
    function int entry_needed(cmd_e cmd);
      if (cmd == CmdStart && start_status() == StOk) return 0;
      if (cmd == CmdExpiry && running && reps_done < rep_limit && remain == 0) return ptr;
      return -1;
    endfunction

    function bit timer_shot(output shot_t s);
      s = '0;
      if (!running) return 1'b0;
      s.period = period;
      if (reps_done >= rep_limit) begin
        running = 1'b0;
        s.fin = 1'b1;
        return 1'b1;
      end
      s.on = level;
      if (remain == 0) remain = 26'(period) * 26'(durations[ptr]);
      s.chunk = (remain > 26'(ChunkMax)) ? ChunkMax : remain[15:0];
      remain = remain - 26'(s.chunk);
      if (remain == 0) begin
        level = ~level;
        ptr = ptr + 10'd1;
        if (ptr >= run_len) begin
          reps_done = reps_done + 8'd1;
          ptr = run_off - 10'd1;
        end
      end
      return 1'b1;
    endfunction

    // Returns 1 unless the item is ignored by the block.
    function bit take_item(cmd_e cmd, logic [9:0] idx, logic [15:0] val);
      shot_t s;
      bit got;
      int unsigned q;
      s = '0;
      got = 1'b0;
      case (cmd)
        CmdLoad: begin
          durations[idx] = val;
          written[idx] = 1'b1;
          return 1'b1;
        end
        CmdStart: begin
          s.status = start_status();
          if (s.status != StOk) begin
            got = 1'b1;
          end else begin
            q = TickHz / freq;
            period = q[9:0];
            rep_limit = (rep_cfg == 0) ? CountDefault : rep_cfg[7:0];
            run_len = seq_len;
            run_off = offset;
            level = 1'b1;
            ptr = '0;
            reps_done = '0;
            remain = '0;
            running = 1'b1;
            got = timer_shot(s);
          end
        end
        CmdExpiry: got = timer_shot(s);
        default: begin
          got = running;
          if (running) begin
            running = 1'b0;
            s.period = period;
            s.fin = 1'b1;
          end
        end
      endcase
      if (got) shots_due.push_back(s);
      return got;
    endfunction

    function int pending();
      return shots_due.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_shot(shot_t got);
      shot_t want;
      string bad;
      if (shots_due.size() == 0) begin
        report($sformatf("result with none expected: %p", got));
        return;
      end
      want = shots_due.pop_front();
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.on !== want.on) bad = {bad, " carrier_on"};
      if (got.period !== want.period) bad = {bad, " carrier_period"};
      if (got.chunk !== want.chunk) bad = {bad, " chunk_ticks"};
      if (got.fin !== want.fin) bad = {bad, " finished"};
      if (bad != "") report($sformatf("wrong%s: got %p, want %p", bad, got, want));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CmdLoad;
  logic [9:0]  entry_index_i = '0;
  logic [15:0] entry_value_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegFreq;
  logic [19:0] cfg_data_i = '0;
  logic        done_o;
  logic [3:0]  status_o;
  logic        carrier_on_o;
  logic [9:0]  carrier_period_o;
  logic [15:0] chunk_ticks_o;
  logic        finished_o;

  ir_player_board board;
  int items = 0;
  int gap_pct = 38;
  int quiet = 0;
  bit full_done = 1'b0;

  ir_pulse_sequence_player DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .entry_index_i    (entry_index_i),
    .entry_value_i    (entry_value_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .carrier_on_o     (carrier_on_o),
    .carrier_period_o (carrier_period_o),
    .chunk_ticks_o    (chunk_ticks_o),
    .finished_o       (finished_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_shot('{status: status_o, on: carrier_on_o, period: carrier_period_o,
                         chunk: chunk_ticks_o, fin: finished_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QuietLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  function automatic logic [15:0] rand_dur();
    case ($urandom_range(19))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(65535));
      3, 4, 5: return 16'($urandom_range(300, 3000));
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic send(cmd_e cmd, logic [9:0] idx, logic [15:0] val);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    entry_index_i <= idx;
    entry_value_i <= val;
    do @(posedge clk_i); while (busy_o);
    if (board.take_item(cmd, idx, val)) items++;
  endtask

  // Loads a store entry first when the item would read one never written.
  task automatic play(cmd_e cmd);
    int need;
    need = board.entry_needed(cmd);
    if (need >= 0 && !board.written[need]) send(CmdLoad, 10'(need), rand_dur());
    send(cmd, 10'($urandom_range(1023)), 16'($urandom_range(65535)));
  endtask

  // Wait until every expected result is out and the block has gone quiet.
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0 || busy_o);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [19:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.take_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic directed();
    play(CmdExpiry);                // both ignored while idle
    play(CmdStop);
    play(CmdStart);                 // empty sequence
    cfg_write(RegLength, 20'd1019);
    play(CmdStart);
    cfg_write(RegLength, 20'd2);
    cfg_write(RegFreq, 20'd19999);
    play(CmdStart);
    cfg_write(RegFreq, 20'd500001);
    play(CmdStart);
    cfg_write(RegFreq, 20'd500000);
    cfg_write(RegRepeat, 20'd32);
    play(CmdStart);
    cfg_write(RegRepeat, 20'd1);
    cfg_write(RegOffset, 20'd0);
    play(CmdStart);
    cfg_write(RegOffset, 20'd2);
    play(CmdStart);
    cfg_write(RegOffset, 20'd1);
    cfg_write(RegLength, 20'd3);
    play(CmdStart);
    cfg_write(RegLength, 20'd2);
    cfg_write(RegOffset, 20'd3);
    play(CmdStart);
    cfg_write(RegOffset, 20'd1);
    send(CmdLoad, 10'd0, 16'd2100); // splits into two shots at 32 ticks a period
    send(CmdLoad, 10'd1, 16'd0);
    send(CmdLoad, 10'd1023, 16'hFFFF);
    play(CmdStart);
    play(CmdStart);                 // busy
    play(CmdExpiry);
    play(CmdExpiry);                // zero-length space
    play(CmdExpiry);                // last repeat done
    play(CmdStart);
    cfg_write(RegFreq, 20'd20000);  // latched period must stay
    play(CmdExpiry);
    play(CmdStop);
  endtask

  task automatic session(bit full_play);
    int len, r, left;
    if (full_play) begin
      cfg_write(RegFreq, 20'd500000);
      cfg_write(RegRepeat, 20'd0);
      cfg_write(RegLength, 20'd4);
      cfg_write(RegOffset, 20'd3);
    end else begin
      if ($urandom_range(4) != 0) begin
        case ($urandom_range(15))
          0:       cfg_write(RegFreq, 20'd20000);
          1:       cfg_write(RegFreq, 20'd500000);
          2:       cfg_write(RegFreq, 20'd19999);
          3:       cfg_write(RegFreq, 20'd500001);
          4:       cfg_write(RegFreq, 20'($urandom_range(500002, 1048575)));
          5:       cfg_write(RegFreq, 20'($urandom_range(19998)));
          default: cfg_write(RegFreq, 20'($urandom_range(20000, 500000)));
        endcase
      end
      if ($urandom_range(4) != 0) begin
        case ($urandom_range(11))
          0:       cfg_write(RegRepeat, 20'd0);
          1:       cfg_write(RegRepeat, 20'd31);
          2:       cfg_write(RegRepeat, 20'($urandom_range(32, 65535)));
          default: cfg_write(RegRepeat, 20'($urandom_range(1, 3)));
        endcase
      end
      case ($urandom_range(11))
        0: len = 1018;
        1: begin
          case ($urandom_range(3))
            0:       len = 0;
            1:       len = 1;
            2:       len = 2 * $urandom_range(1, 9) + 1;
            default: len = $urandom_range(1019, 1023);
          endcase
        end
        default: len = 2 * $urandom_range(1, 4);
      endcase
      cfg_write(RegLength, 20'(len));
      case ($urandom_range(11))
        0:       cfg_write(RegOffset, 20'd0);
        1:       cfg_write(RegOffset, 20'(2 * $urandom_range(1, 5)));
        2:       cfg_write(RegOffset, 20'((len + 1) | 1));
        default: cfg_write(RegOffset, 20'(2 * $urandom_range(0, (len - 1) / 2) + 1));
      endcase
    end
    for (int i = 0; i < board.seq_len && i < 8; i++) begin
      send(CmdLoad, 10'(i), full_play ? 16'($urandom_range(1, 3)) : rand_dur());
    end
    play(CmdStart);
    left = full_play ? 100000 : $urandom_range(4, 120);
    while (board.running && left > 0) begin
      r = full_play ? 0 : $urandom_range(99);
      if (r < 80 || r >= 94) begin
        play(CmdExpiry);
      end else if (r < 86) begin
        send(CmdLoad, 10'($urandom_range(1023)), 16'($urandom_range(65535)));
      end else if (r < 89) begin
        play(CmdStart);
      end else if (r < 91) begin
        play(CmdStop);
      end else if (r < 93) begin
        settle();
      end else begin
        cfg_write(cfg_idx_e'($urandom_range(3)), 20'($urandom));
      end
      left--;
    end
    if (board.running) play(CmdStop);
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(1) != 0) play(CmdExpiry);
      else play(CmdStop);
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    while (items < 1000) begin
      gap_pct = (items < 350) ? 38 : (items < 700) ? 61 : 0;
      if (!full_done && items >= 400) begin
        session(1'b1);
        full_done = 1'b1;
      end else begin
        session(1'b0);
      end
    end
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
